// ----- rtl/cplx_pkg.sv -----
// Package for the charlieplexed PWM LED driver.
// Holds register indexes, mode codes, shared types and the pin-mapping functions.
// No dependencies.
package cplx_pkg;

    localparam int NUM_PINS     = 3;
    localparam int NUM_LEDS     = 6;
    localparam int BRIGHT_W     = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int PWM_BITS_DEF = 8;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_SCAN   = 2'd1;
    localparam logic [1:0] MODE_SINGLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_LED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_3   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_4   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_5   = 3'd7;

    typedef logic [NUM_PINS-1:0] pin_t;
    typedef logic [BRIGHT_W-1:0] bright_t;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [2:0]                 single_led;
        bright_t [NUM_LEDS-1:0]     brightness;
    } cfg_t;

    typedef struct packed {
        logic [1:0] low_pin;
        pin_t       pin_enable;
        pin_t       pin_level;
    } pin_state_t;

    // k-th of the two pins other than lo, in ascending order
    function automatic logic [1:0] high_pin(input logic [1:0] lo, input logic k);
        logic [1:0] kk;
        kk = {1'b0, k};
        return (kk < lo) ? kk : kk + 2'd1;
    endfunction

    function automatic pin_t pin_bit(input logic [1:0] p);
        return pin_t'(3'b001 << p);
    endfunction

endpackage

// ----- rtl/cplx_if.sv -----
// Channel interfaces for the charlieplexed PWM LED driver: tick input and pin result.
// Depends on cplx_pkg.
interface cplx_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

interface cplx_pins_if;
    logic             valid;
    logic             ready;
    cplx_pkg::pin_t   drive_enable;
    cplx_pkg::pin_t   drive_level;

    modport source (output valid, output drive_enable, output drive_level, input ready);
    modport sink (input valid, input drive_enable, input drive_level, output ready);
endinterface

// ----- rtl/cplx_cfg_regs.sv -----
// Configuration register file: mode, single LED index and six brightness values.
// Depends on cplx_pkg.
module cplx_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cplx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cplx_pkg::CFG_DATA_W-1:0]   cfg_data,
    output cplx_pkg::cfg_t                    cfg
);
    import cplx_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODE:       cfg_next.mode          = cfg_data[1:0];
                REG_SINGLE_LED: cfg_next.single_led    = cfg_data[2:0];
                REG_BRIGHT_0:   cfg_next.brightness[0] = cfg_data[BRIGHT_W-1:0];
                REG_BRIGHT_1:   cfg_next.brightness[1] = cfg_data[BRIGHT_W-1:0];
                REG_BRIGHT_2:   cfg_next.brightness[2] = cfg_data[BRIGHT_W-1:0];
                REG_BRIGHT_3:   cfg_next.brightness[3] = cfg_data[BRIGHT_W-1:0];
                REG_BRIGHT_4:   cfg_next.brightness[4] = cfg_data[BRIGHT_W-1:0];
                REG_BRIGHT_5:   cfg_next.brightness[5] = cfg_data[BRIGHT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/cplx_step.sv -----
// Next-state logic for one tick: PWM scan phase update or static pin pattern.
// Depends on cplx_pkg.
module cplx_step #(
    parameter int PWM_BITS = cplx_pkg::PWM_BITS_DEF
) (
    input  cplx_pkg::cfg_t        cfg,
    input  logic                  tick,
    input  logic [PWM_BITS-1:0]   pwm_count,
    input  cplx_pkg::pin_state_t  state,
    output logic [PWM_BITS-1:0]   pwm_count_next,
    output cplx_pkg::pin_state_t  state_next
);
    import cplx_pkg::*;

    localparam int CMP_W = (PWM_BITS > BRIGHT_W) ? PWM_BITS : BRIGHT_W;

    logic                count_zero;
    logic [1:0]          lo;
    pin_t                scan_en;
    pin_t                scan_lvl;
    bright_t             val [2];
    pin_t                hb [2];
    logic [CMP_W-1:0]    count_ext;
    logic [1:0]          s_lo;
    logic [1:0]          s_hi;
    pin_state_t          static_state;

    assign count_zero = (pwm_count == '0);
    assign count_ext  = CMP_W'(pwm_count);

    always_comb
    begin
        lo       = state.low_pin;
        scan_en  = state.pin_enable;
        scan_lvl = state.pin_level;
        if (count_zero)
        begin
            lo       = (state.low_pin >= 2'd2) ? 2'd0 : state.low_pin + 2'd1;
            scan_en  = pin_bit(lo);
            scan_lvl = '0;
        end

        case (lo)
            2'd0:
            begin
                val[0] = cfg.brightness[0];
                val[1] = cfg.brightness[1];
            end
            2'd1:
            begin
                val[0] = cfg.brightness[2];
                val[1] = cfg.brightness[3];
            end
            2'd2:
            begin
                val[0] = cfg.brightness[4];
                val[1] = cfg.brightness[5];
            end
            default:
            begin
                val[0] = '0;
                val[1] = '0;
            end
        endcase

        for (int k = 0; k < 2; k++)
        begin
            hb[k] = pin_bit(high_pin(lo, k[0]));
            if (count_zero && (val[k] != '0))
            begin
                scan_en  = scan_en | hb[k];
                scan_lvl = scan_lvl | hb[k];
            end
            else if (CMP_W'(val[k]) == count_ext)
            begin
                scan_en  = scan_en & ~hb[k];
                scan_lvl = scan_lvl & ~hb[k];
            end
        end
    end

    always_comb
    begin
        s_lo         = cfg.single_led[2:1];
        s_hi         = high_pin(s_lo, cfg.single_led[0]);
        static_state = '{low_pin: state.low_pin, pin_enable: '0, pin_level: '0};
        if ((cfg.mode == MODE_SINGLE) && (cfg.single_led < 3'(NUM_LEDS)))
        begin
            static_state.pin_enable = pin_bit(s_lo) | pin_bit(s_hi);
            static_state.pin_level  = pin_bit(s_hi);
        end
    end

    always_comb
    begin
        if (cfg.mode == MODE_SCAN)
        begin
            if (tick)
            begin
                pwm_count_next = pwm_count + 1'b1;
                state_next     = '{low_pin: lo, pin_enable: scan_en, pin_level: scan_lvl};
            end
            else
            begin
                pwm_count_next = pwm_count;
                state_next     = state;
            end
        end
        else
        begin
            pwm_count_next = '0;
            state_next     = static_state;
        end
    end

endmodule

// ----- rtl/charlieplex_pwm_led_driver.sv -----
// Charlieplexed PWM LED driver top level: six LEDs on three tri-state pins.
// Each accepted tick updates the scan state in the same cycle and the pin
// state register is the result: one tick per clock unless pins stall, and a
// new tick is taken while the previous result waits, as long as the result
// is taken in the same cycle. PWM period is 2^PWM_BITS ticks per phase.
// Depends on cplx_pkg, cplx_if, cplx_cfg_regs and cplx_step.
module charlieplex_pwm_led_driver #(
    parameter int PWM_BITS = cplx_pkg::PWM_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cplx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cplx_pkg::CFG_DATA_W-1:0]   cfg_data,
    cplx_tick_if.sink                         ticks,
    cplx_pins_if.source                       pins
);
    import cplx_pkg::*;

    cfg_t                   cfg;
    logic                   accept;
    logic                   valid_reg;
    logic                   valid_next;
    logic [PWM_BITS-1:0]    count_reg;
    logic [PWM_BITS-1:0]    count_next;
    pin_state_t             state_reg;
    pin_state_t             state_next;

    cplx_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cplx_step #(
        .PWM_BITS (PWM_BITS)
    ) u_step (
        .cfg            (cfg),
        .tick           (ticks.tick),
        .pwm_count      (count_reg),
        .state          (state_reg),
        .pwm_count_next (count_next),
        .state_next     (state_next)
    );

    assign ticks.ready = !valid_reg || pins.ready;
    assign accept      = ticks.valid && ticks.ready;
    assign valid_next  = accept || (valid_reg && !pins.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
            state_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                count_reg <= count_next;
                state_reg <= state_next;
            end
        end
    end

    assign pins.valid        = valid_reg;
    assign pins.drive_enable = state_reg.pin_enable;
    assign pins.drive_level  = state_reg.pin_level & state_reg.pin_enable;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pins.valid)
        else $error("transfer accepted without a result");

    a_low_pin_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.low_pin != 2'd3)
        else $error("low pin index out of range");

    a_level_in_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.pin_level & ~state_reg.pin_enable) == '0)
        else $error("level set on floating pin");

    a_off_floats: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cfg.mode != MODE_SCAN) && (cfg.mode != MODE_SINGLE))
            |=> (state_reg.pin_enable == '0) && (count_reg == '0))
        else $error("pins driven in off mode");

endmodule
